@@ sv/vfsd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vfsd_pkg
// Shared types and constants for the VLAN first-seen detector.
// ============================================================================
package vfsd_pkg;

  // Fixed field widths
  localparam int VID_W   = 12;
  localparam int ETYPE_W = 16;
  localparam int PORT_W  = 16;
  localparam int WIDX_W  = 6;
  localparam int MWORD_W = 64;

  // Default geometry
  localparam int VID_COUNT_DEF = 4096;
  localparam int WORD_BITS_DEF = 64;

  // Item modes
  localparam logic [1:0] MODE_FRAME = 2'd0;
  localparam logic [1:0] MODE_REARM = 2'd1;
  localparam logic [1:0] MODE_MASK  = 2'd2;

  // Ethertypes of interest
  localparam logic [ETYPE_W-1:0] ET_IPV4       = 16'h0800;
  localparam logic [ETYPE_W-1:0] ET_ARP        = 16'h0806;
  localparam logic [ETYPE_W-1:0] ET_PPPOE_DISC = 16'h8863;

  // Register index (byte address bit 2)
  localparam logic REG_CLASS_ENABLE = 1'b0;
  localparam logic REG_PORT_INDEX   = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic               tag_present;
    logic [ETYPE_W-1:0] ethertype;
    logic [VID_W-1:0]   vlan_id;
    logic               class_sel;
    logic [WIDX_W-1:0]  word_index;
    logic [MWORD_W-1:0] word_value;
  } frame_t;

  typedef struct packed {
    logic [PORT_W-1:0]  report_port;
    logic [VID_W-1:0]   report_vid;
    logic [ETYPE_W-1:0] report_ethertype;
  } report_t;

  // Store access command
  typedef struct packed {
    logic en;
    logic we;
  } mem_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_UPDATE
  } state_t;

endpackage

@@ sv/vlan_first_seen_detector_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vlan_first_seen_detector_top
// Reports the first tagged frame seen per VLAN ID and protocol class.
// ============================================================================
// Usage:
//   frame channel (valid/ready) carries frame descriptors and commands:
//   mode 0 frame, mode 1 re-arm one VID, mode 2 write one mask word.
//   report channel (valid/ready) carries one item per newly seen VID.
//   APB port: reg 0 (addr 0) class_enable, reg 1 (addr 4) port_index.
// Timing:
//   A frame or re-arm that touches the store goes through accept, divide,
//   read and modify/write before the next accept; a mask write goes
//   through accept, divide and write. A report is valid the cycle after
//   the modify step. An item that is filtered out goes through accept
//   and divide only. The rate is set by the single read port of the
//   bitmap and the read-modify-write sequencer around it.
// Reset:
//   Registers clear at once; the bitmap is then swept to zero, one word a
//   cycle, over 2*(VID_COUNT/WORD_BITS) words (a word more when VID_COUNT is
//   not a multiple of WORD_BITS). No item is accepted during the sweep.
// Stall:
//   A waiting report does not block new items; only an item that needs a
//   report while the previous one is untaken waits in the modify step.
// ============================================================================
module vlan_first_seen_detector_top #(
  parameter int VID_COUNT = vfsd_pkg::VID_COUNT_DEF,
  parameter int WORD_BITS = vfsd_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // frame item channel
  input  logic              frame_valid,
  output logic              frame_ready,
  input  vfsd_pkg::frame_t  frame,
  // report item channel
  output logic              report_valid,
  input  logic              report_ready,
  output vfsd_pkg::report_t report,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import vfsd_pkg::*;

  // Store geometry
  localparam int WPC    = VID_COUNT / WORD_BITS;          // words per class
  localparam int QMAX   = (VID_COUNT - 1) / WORD_BITS;    // largest word index
  localparam int DEPTH  = WPC + QMAX + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int QW     = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);

  // vid / WORD_BITS by reciprocal: exact for 12-bit numerators
  localparam int SHIFT   = VID_W + BIT_W;
  localparam int RECIP_W = VID_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS);
  localparam int PROD_W  = VID_W + RECIP_W;

  localparam logic [VID_W:0]    VID_LIMIT = (VID_W + 1)'(VID_COUNT);
  localparam logic [10:0]       WPC_L     = 11'(WPC);
  localparam logic [ADDR_W-1:0] WPC_A     = ADDR_W'(WPC);
  localparam logic [VID_W-1:0]  WB_L      = VID_W'(WORD_BITS);

  // ---------------------------------------------------------------- config
  logic [1:0]        class_enable;
  logic [PORT_W-1:0] port_index;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_enable <= '0;
      port_index   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CLASS_ENABLE: class_enable <= pwdata[1:0];
        REG_PORT_INDEX:   port_index   <= pwdata[PORT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CLASS_ENABLE: prdata = {30'b0, class_enable};
      REG_PORT_INDEX:   prdata = {16'b0, port_index};
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- item
  state_t state, state_next;
  frame_t item;
  logic   [QW-1:0]    q_reg;
  logic   [BIT_W-1:0] r_reg;
  logic               cls_reg;

  logic               store_busy;
  mem_cmd_t           mem_cmd;
  logic [ADDR_W-1:0]  mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  // classification (valid while in ST_DIV)
  logic is_ip, is_pd, vid_ok, widx_ok, frame_ok, act, cls;
  logic [PROD_W-1:0] prod;
  logic [VID_W-1:0]  qw;

  assign is_ip   = (item.ethertype == ET_IPV4) || (item.ethertype == ET_ARP);
  assign is_pd   = (item.ethertype == ET_PPPOE_DISC);
  assign vid_ok  = {1'b0, item.vlan_id} < VID_LIMIT;
  assign widx_ok = {5'b0, item.word_index} < WPC_L;
  assign frame_ok = item.tag_present && (is_ip || is_pd) &&
                    class_enable[is_pd] && vid_ok;
  assign cls = (item.mode == MODE_FRAME) ? is_pd : item.class_sel;

  always_comb begin
    unique case (item.mode)
      MODE_FRAME: act = frame_ok;
      MODE_REARM: act = vid_ok;
      MODE_MASK:  act = widx_ok;
      default:    act = 1'b0;
    endcase
  end

  assign prod = PROD_W'(item.vlan_id) * PROD_W'(RECIP);
  assign qw   = VID_W'(q_reg) * WB_L;

  // word address and bit select
  logic [ADDR_W-1:0]    base, vid_addr, mask_addr;
  logic [WORD_BITS-1:0] bit_sel;
  logic                 hit, out_free;

  assign base      = cls_reg ? WPC_A : '0;
  assign vid_addr  = ADDR_W'(q_reg) + base;
  assign mask_addr = ADDR_W'(item.word_index) + base;
  assign bit_sel   = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_reg;
  assign hit       = |(mem_rdata & bit_sel);
  assign out_free  = !report_valid || report_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic report_load;

  always_comb begin
    state_next  = state;
    mem_cmd     = '0;
    mem_addr    = vid_addr;
    mem_wdata   = mem_rdata | bit_sel;
    report_load = 1'b0;
    frame_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        frame_ready = !store_busy;
        if (frame_valid && !store_busy) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        state_next = act ? ST_ADDR : ST_IDLE;
      end
      ST_ADDR: begin
        mem_cmd.en = 1'b1;
        if (item.mode == MODE_MASK) begin
          mem_cmd.we = 1'b1;
          mem_addr   = mask_addr;
          mem_wdata  = item.word_value[WORD_BITS-1:0];
          state_next = ST_IDLE;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (item.mode == MODE_FRAME) begin
          if (hit) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            mem_cmd     = '{en: 1'b1, we: 1'b1};
            report_load = 1'b1;
            state_next  = ST_IDLE;
          end
        end else begin
          mem_cmd    = '{en: 1'b1, we: 1'b1};
          mem_wdata  = mem_rdata & ~bit_sel;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      item <= frame;
    end
    if (state == ST_DIV) begin
      q_reg   <= QW'(prod >> SHIFT);
      cls_reg <= cls;
    end
    if (state == ST_ADDR) begin
      r_reg <= BIT_W'(item.vlan_id - qw);
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (report_load) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_load) begin
      report.report_port      <= port_index;
      report.report_vid       <= item.vlan_id;
      report.report_ethertype <= item.ethertype;
    end
  end

  vfsd_seen_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .ADDR_W    (ADDR_W)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata),
    .busy  (store_busy)
  );

`ifndef SYNTH
  // no item taken and no store access during the clearing sweep
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> (!frame_ready && !mem_cmd.en))
    else $error("item or store access during clearing sweep");

  // one item at a time: ready only when the sequencer is idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    frame_ready |-> (state == ST_IDLE))
    else $error("ready outside idle state");

  // reports come only from a frame that found its bit clear
  a_report_src: assert property (@(posedge clk) disable iff (rst)
    report_load |-> (state == ST_UPDATE && item.mode == MODE_FRAME && !hit
                     && mem_cmd.we))
    else $error("report without first-seen write");

  // a read is always followed by its modify step
  a_read_update: assert property (@(posedge clk) disable iff (rst)
    (mem_cmd.en && !mem_cmd.we) |=> (state == ST_UPDATE))
    else $error("store read not followed by update");
`endif

endmodule

@@ sv/vfsd_seen_store.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vfsd_seen_store
// Single-port seen bitmap memory, registered read, cleared by a sweep after
// reset.
// ============================================================================
module vfsd_seen_store #(
  parameter int DEPTH     = 128,
  parameter int WORD_BITS = 64,
  parameter int ADDR_W    = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vfsd_pkg::mem_cmd_t   cmd,
  input  logic [ADDR_W-1:0]    addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata,
  output logic                 busy
);
  import vfsd_pkg::*;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]    clr_addr;
  logic                 clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (cmd.en && cmd.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && !cmd.we) begin
      rdata <= mem[addr];
    end
  end

  assign busy = clearing;

endmodule
